@@ rtl/core/thn_pkg.sv @@
// shared types, widths and helpers for the two-hop neighbor unit
// no dependencies; imported by the controller, datapath and top level
package thn_pkg;

  localparam int INDEX_W       = 5;
  localparam int BITS_W        = 32;
  localparam int CFG_W         = 6;
  localparam int TDATA_W       = 40;
  localparam int MAX_NODES_DEF = 32;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 6'd32;

  // controller to datapath
  typedef struct packed {
    logic load;    // input side open, rows are written
    logic start;   // run begins: clear marks, row counter to zero
    logic rd_row;  // read adjacency row i
    logic head;    // latch row i, start scan at column zero
    logic scan;    // fold in one neighbor row per cycle
    logic mark;    // finish row i and merge it into the mark matrix
    logic emit;    // load result row i into the output register
  } thn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // neighbor scan reached the last node in use
    logic row_last;   // row counter at the last node in use
    logic out_free;   // output register can take a word
  } thn_status_t;

  // ones in the low n bits
  function automatic logic [BITS_W-1:0] low_mask(input logic [CFG_W-1:0] n);
    logic [BITS_W-1:0] m;
    m = '0;
    for (int b = 0; b < BITS_W; b++) begin
      m[b] = (CFG_W'(b) < n);
    end
    return m;
  endfunction

endpackage

@@ rtl/core/thn_ctrl.sv @@
// sequencer for the two-hop neighbor unit: load, scan, mark and emit phases
// depends on thn_pkg for the command and status structs
module thn_ctrl
  import thn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tlast,
  output logic        s_axis_tready,
  input  thn_status_t st,
  output thn_cmd_t    cmd
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_MARK = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.load = 1'b1;
        if (s_axis_tvalid && s_axis_tlast) begin
          cmd.start  = 1'b1;
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        cmd.rd_row = 1'b1;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.head   = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_next = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark   = 1'b1;
        state_next = st.row_last ? S_EMIT : S_ROW;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.row_last) begin
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  assign s_axis_tready = cmd.load;

  // the word carrying the last row closes the input until the run is out
  a_close_after_last: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after last row");

  // no result is loaded while the output register is still full
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("emit into a full output register");

  // scanning only ever follows a row head or continues a scan
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ($past(state) == S_HEAD || $past(state) == S_SCAN))
    else $error("scan entered out of order");

endmodule

@@ rtl/core/thn_datapath.sv @@
// datapath: adjacency memory, row scan accumulator, mark matrix, output register
// depends on thn_pkg; driven by thn_ctrl through thn_cmd_t
module thn_datapath
  import thn_pkg::*;
#(
  parameter int NODE_LIMIT = MAX_NODES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  thn_cmd_t            cmd,
  output thn_status_t         st,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                in_valid,
  input  logic [INDEX_W-1:0]  in_index,
  input  logic [BITS_W-1:0]   in_bits,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [INDEX_W-1:0]  out_index,
  output logic [BITS_W-1:0]   out_bits,
  output logic                out_last
);

  localparam int IDX_W = $clog2(NODE_LIMIT);
  localparam int CNT_W = $clog2(NODE_LIMIT + 1);

  logic [CFG_W-1:0]  node_count;
  logic [CNT_W-1:0]  n_use;
  logic [CNT_W-1:0]  n_last;
  logic [BITS_W-1:0] mask;

  logic [BITS_W-1:0]     adj_mem [NODE_LIMIT];
  logic [NODE_LIMIT-1:0] vld;
  logic [BITS_W-1:0]     rd_data;
  logic                  rd_vld;
  logic [BITS_W-1:0]     rd_eff;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;

  logic [IDX_W-1:0]      i;
  logic [IDX_W-1:0]      j;
  logic [IDX_W-1:0]      jd;
  logic [NODE_LIMIT-1:0] row;
  logic [BITS_W-1:0]     reach;
  logic [BITS_W-1:0]     self_bit;
  logic [BITS_W-1:0]     mark_row;
  logic [BITS_W-1:0]     mark_store [NODE_LIMIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  // count in use, saturated to 1..NODE_LIMIT
  always_comb begin
    if (node_count == '0) begin
      n_use = CNT_W'(1);
    end else if (node_count > CFG_W'(NODE_LIMIT)) begin
      n_use = CNT_W'(NODE_LIMIT);
    end else begin
      n_use = CNT_W'(node_count);
    end
  end

  assign n_last = n_use - CNT_W'(1);
  assign mask   = low_mask(CFG_W'(n_use));

  // adjacency memory, one write and one registered read port
  assign wr_en   = cmd.load && in_valid && (CFG_W'(in_index) < CFG_W'(n_use));
  assign rd_addr = cmd.rd_row ? i : (cmd.head ? '0 : j);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      adj_mem[in_index[IDX_W-1:0]] <= in_bits;
    end
    rd_data <= adj_mem[rd_addr];
  end

  // rows not written since the last run read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (cmd.emit && st.row_last) begin
        vld <= '0;
      end else if (wr_en) begin
        vld[in_index[IDX_W-1:0]] <= 1'b1;
      end
    end
  end

  assign rd_eff = rd_vld ? (rd_data & mask) : '0;

  // row and scan counters
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i <= '0;
    end else if (cmd.mark) begin
      i <= st.row_last ? '0 : i + IDX_W'(1);
    end else if (cmd.emit) begin
      i <= i + IDX_W'(1);
    end
    if (cmd.head) begin
      j  <= IDX_W'(1);
      jd <= '0;
    end else if (cmd.scan) begin
      j  <= j + IDX_W'(1);
      jd <= j;
    end
  end

  // or together the rows of every neighbor other than i itself
  always_ff @(posedge clk) begin
    if (cmd.head) begin
      row   <= rd_eff[NODE_LIMIT-1:0];
      reach <= '0;
    end else if (cmd.scan && row[jd] && (jd != i)) begin
      reach <= reach | rd_eff;
    end
  end

  assign self_bit = BITS_W'(1) << i;
  assign mark_row = reach & ~BITS_W'(row) & ~self_bit & mask;

  // mark matrix kept symmetric: row i gets M[i], column i gets M[i] too
  always_ff @(posedge clk) begin
    for (int r = 0; r < NODE_LIMIT; r++) begin
      if (cmd.start) begin
        mark_store[r] <= '0;
      end else if (cmd.mark) begin
        mark_store[r] <= mark_store[r]
                       | ((IDX_W'(r) == i) ? mark_row : '0)
                       | (mark_row[r] ? self_bit : '0);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index <= INDEX_W'(i);
      out_bits  <= mark_store[i];
      out_last  <= st.row_last;
    end
  end

  assign st.scan_done = (CNT_W'(jd) == n_last);
  assign st.row_last  = (CNT_W'(i) == n_last);
  assign st.out_free  = !out_valid || out_ready;

  // adjacency store is empty again once the final result row is loaded
  a_clear_after_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && st.row_last) |=> (vld == '0))
    else $error("adjacency rows still valid after the run");

  // a word held in the output register does not change until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(out_valid) && !$past(out_ready) && !$past(rst)) |-> $stable(out_bits))
    else $error("pending result overwritten");

endmodule

@@ rtl/core/two_hop_nonadjacent_neighbors_unit.sv @@
// Two-hop non-adjacent neighbor unit. Adjacency rows stream in one word per
// cycle while the input side is open; the word with tlast set starts a run
// that, for each node i, ORs the rows of i's neighbors from the adjacency
// memory one per cycle (one memory read port); a run of n nodes then emits n
// result words, one per cycle while the output side is ready. The input side
// is closed from the last row until the final result word is in the output
// register. Results are symmetric: word i holds node i's marks ORed with
// column i of the mark matrix. The node count register may only be written
// while no run is in progress.
// depends on thn_pkg, thn_ctrl and thn_datapath
module two_hop_nonadjacent_neighbors_unit
  import thn_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,   // node_count
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // [4:0] row_index, [36:5] row_bits, rest zero
  input  logic               s_axis_tlast,  // last_row
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,  // [4:0] out_index, [36:5] out_bits, rest zero
  output logic               m_axis_tlast   // out_last
);

  localparam int NODE_LIMIT = (MAX_NODES < BITS_W) ? MAX_NODES : BITS_W;

  thn_cmd_t           cmd;
  thn_status_t        st;
  logic [INDEX_W-1:0] out_index;
  logic [BITS_W-1:0]  out_bits;

  thn_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .st            (st),
    .cmd           (cmd)
  );

  thn_datapath #(
    .NODE_LIMIT (NODE_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_index  (s_axis_tdata[INDEX_W-1:0]),
    .in_bits   (s_axis_tdata[INDEX_W+BITS_W-1:INDEX_W]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_index (out_index),
    .out_bits  (out_bits),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(TDATA_W-INDEX_W-BITS_W){1'b0}}, out_bits, out_index};

endmodule

@@ tb/sv/two_hop_row_checker.sv @@
// result checker for the two-hop neighbor unit: follows the node count port and
// both streams, predicts every result word and compares it field by field
// depends on thn_pkg
module two_hop_row_checker
  import thn_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,
  input  logic               s_axis_tlast,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [TDATA_W-1:0] m_axis_tdata,
  input  logic               m_axis_tlast,
  output int                 error_count,
  output int                 rows_pending
);

  localparam int NODE_LIMIT   = 32;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [INDEX_W-1:0] node;
    logic [BITS_W-1:0]  reach;
    logic               tail;
  } two_hop_row_t;

  logic [BITS_W-1:0] adjacency [NODE_LIMIT];
  logic [CFG_W-1:0]  node_count;
  two_hop_row_t      two_hop_rows_due [$];

  // count in use, saturated to 1..32
  function automatic int nodes_in_play(input logic [CFG_W-1:0] count);
    if (count == 0) return 1;
    if (count > NODE_LIMIT) return NODE_LIMIT;
    return int'(count);
  endfunction

  function automatic void predict_two_hop_rows(input int n);
    logic [BITS_W-1:0] mask;
    logic [BITS_W-1:0] row;
    logic [BITS_W-1:0] reach;
    logic [BITS_W-1:0] sym;
    logic [BITS_W-1:0] marks [NODE_LIMIT];
    two_hop_row_t      r;
    mask = (n >= BITS_W) ? '1 : (BITS_W'(1) << n) - BITS_W'(1);
    for (int i = 0; i < n; i++) begin
      row   = adjacency[i] & mask;
      reach = '0;
      // a self link is never a hop
      for (int j = 0; j < n; j++) begin
        if (j != i && row[j]) reach |= adjacency[j] & mask;
      end
      marks[i] = reach & ~row & ~(BITS_W'(1) << i) & mask;
    end
    // each word also carries column i of the mark matrix
    for (int i = 0; i < n; i++) begin
      sym = marks[i];
      for (int k = 0; k < n; k++) begin
        if (marks[k][i]) sym[k] = 1'b1;
      end
      r.node  = INDEX_W'(i);
      r.reach = sym;
      r.tail  = (i == n - 1);
      two_hop_rows_due = {two_hop_rows_due, r};
    end
    for (int i = 0; i < NODE_LIMIT; i++) adjacency[i] = '0;
  endfunction

  always @(posedge clk) begin
    logic [INDEX_W-1:0] idx;
    two_hop_row_t       got;
    two_hop_row_t       want;
    int                 n;
    if (rst) begin
      node_count  = NODE_COUNT_RST;
      error_count = 0;
      for (int i = 0; i < NODE_LIMIT; i++) adjacency[i] = '0;
      two_hop_rows_due.delete();
    end else begin
      if (cfg_we) node_count = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        n   = nodes_in_play(node_count);
        idx = s_axis_tdata[INDEX_W-1:0];
        if (idx < n) adjacency[idx] = s_axis_tdata[INDEX_W+BITS_W-1:INDEX_W];
        if (s_axis_tlast) predict_two_hop_rows(n);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.node  = m_axis_tdata[INDEX_W-1:0];
        got.reach = m_axis_tdata[INDEX_W+BITS_W-1:INDEX_W];
        got.tail  = m_axis_tlast;
        if (two_hop_rows_due.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected result word: node %0d bits %h last %b",
                     got.node, got.reach, got.tail);
        end else begin
          want = two_hop_rows_due.pop_front();
          if (got.node !== want.node || got.reach !== want.reach ||
              got.tail !== want.tail) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("mismatch: expected node %0d bits %h last %b, got %0d %h %b",
                       want.node, want.reach, want.tail, got.node, got.reach, got.tail);
          end
        end
      end
    end
    rows_pending <= two_hop_rows_due.size();
  end

endmodule

@@ tb/sv/two_hop_nonadjacent_neighbors_unit_tb.sv @@
// top of the two-hop neighbor unit bench: clock, reset, node count writes,
// adjacency row stimulus, result stream back-pressure and the verdict
// depends on thn_pkg, two_hop_row_checker and the unit itself
module two_hop_nonadjacent_neighbors_unit_tb;
  import thn_pkg::*;

  localparam int IDLE_LIMIT    = 8000;
  localparam int RANDOM_ROWS   = 370;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  logic        hold_go;
  logic        sink_quiet;
  int          sink_wait;
  int          sink_hold;
  int          idle_cycles = 0;
  int          error_count;
  int          rows_pending;
  bit          src_quiet;
  int          nodes_now;
  int          counted_rows;

  two_hop_nonadjacent_neighbors_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  two_hop_row_checker row_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .error_count   (error_count),
    .rows_pending  (rows_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random wait after each word, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
      sink_hold = 0;
    end else begin
      if (hold_go && sink_hold == 0) sink_hold = HOLD_CYCLES;
      if (sink_hold != 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tready && m_axis_tvalid) begin
        sink_wait = sink_quiet ? 0 : $urandom_range(0, 10);
        if (sink_wait != 0) m_axis_tready <= 1'b0;
      end else if (!m_axis_tready) begin
        if (sink_wait != 0) sink_wait--;
        if (sink_wait == 0) m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("two_hop_nonadjacent_neighbors_unit_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [BITS_W-1:0] random_row(input int unsigned density);
    case (density)
      0: return $urandom & $urandom & $urandom;
      1: return $urandom;
      2: return $urandom | $urandom;
      default: return BITS_W'(1) << $urandom_range(0, BITS_W - 1);
    endcase
  endfunction

  // valid stays high after the word is taken; the next call or the caller lowers it
  task automatic send_row(input logic [INDEX_W-1:0] idx, input logic [BITS_W-1:0] bits,
                          input logic last);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_W - INDEX_W - BITS_W){1'b0}}, bits, idx};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    counted_rows++;
  endtask

  // one full graph load, sometimes shuffled, now and then with a row left out
  task automatic send_graph(input int n);
    int          order [32];
    int          pick;
    int          tmp;
    int unsigned density;
    for (int i = 0; i < 32; i++) order[i] = i;
    if ($urandom_range(0, 2) == 0) begin
      for (int i = n - 1; i > 0; i--) begin
        pick        = $urandom_range(0, i);
        tmp         = order[i];
        order[i]    = order[pick];
        order[pick] = tmp;
      end
    end
    density = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i != n - 1 && $urandom_range(0, 9) == 0) continue;
      send_row(INDEX_W'(order[i]), random_row(density), i == n - 1);
    end
  endtask

  // random indexes and stray last flags, closed by a last row
  task automatic send_noise();
    int count;
    count = $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      send_row(INDEX_W'($urandom_range(0, 31)), random_row($urandom_range(0, 3)),
               $urandom_range(0, 5) == 0);
    end
    send_row(INDEX_W'($urandom_range(0, 31)), $urandom, 1'b1);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // node count is only written with the unit idle
  task automatic set_node_count(input logic [CFG_W-1:0] count);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    nodes_now = (count == 0) ? 1 : (count > 32) ? 32 : int'(count);
    src_quiet = ($urandom_range(0, 3) == 0);
    sink_quiet <= ($urandom_range(0, 3) == 0);
  endtask

  initial begin
    int unsigned      pick;
    logic [CFG_W-1:0] count;
    int               phase_no;
    int               runs;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    hold_go       <= 1'b0;
    sink_quiet    <= 1'b0;
    src_quiet     = 1'b0;
    nodes_now     = 32;
    counted_rows  = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset count of 32, field extremes
    send_row(5'd0, 32'hFFFF_FFFF, 1'b0);
    send_row(5'd31, 32'h0000_0001, 1'b0);
    send_row(5'd16, 32'h8000_0000, 1'b0);
    send_row(5'd5, 32'h0000_0000, 1'b1);

    // single node: self link and high bits only, then an ignored row that still starts a run
    set_node_count(6'd1);
    send_row(5'd0, 32'hFFFF_FFFF, 1'b1);
    send_row(5'd17, 32'hFFFF_FFFF, 1'b1);

    // zero acts as one node
    set_node_count(6'd0);
    send_row(5'd0, 32'h0000_0001, 1'b1);

    // path 0-1-2 with a self link, masked high bits and an out-of-range row
    set_node_count(6'd3);
    send_row(5'd0, 32'h0000_0003, 1'b0);
    send_row(5'd1, 32'h0000_0005, 1'b0);
    send_row(5'd31, 32'h0000_0007, 1'b0);
    send_row(5'd2, 32'hFFFF_FFFA, 1'b1);
    // one-way links: marks are made symmetric on output
    send_row(5'd0, 32'h0000_0002, 1'b0);
    send_row(5'd1, 32'h0000_0004, 1'b1);

    // counts above the limit saturate
    set_node_count(6'd63);
    send_row(5'd31, 32'hFFFF_FFFF, 1'b0);
    send_row(5'd30, 32'h4000_0001, 1'b0);
    send_row(5'd0, 32'h8000_0000, 1'b1);

    // result side held off while further graphs are offered, so the input stalls
    set_node_count(6'd5);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (3) send_graph(5);

    phase_no = 0;
    while (counted_rows < RANDOM_ROWS) begin
      case (phase_no)
        0: count = 6'd32;
        1: count = 6'd1;
        2: count = 6'd2;
        3: count = 6'd0;
        4: count = 6'd63;
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 4) count = CFG_W'($urandom_range(1, 4));
          else if (pick < 8) count = CFG_W'($urandom_range(5, 12));
          else if (pick == 8) count = CFG_W'($urandom_range(13, 32));
          else count = CFG_W'($urandom_range(0, 1) ? 0 : $urandom_range(33, 63));
        end
      endcase
      set_node_count(count);
      runs = (nodes_now > 12) ? 1 : $urandom_range(2, 5);
      repeat (runs) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else send_graph(nodes_now);
      end
      phase_no++;
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (rows_pending != 0);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("two_hop_nonadjacent_neighbors_unit_tb: PASS");
    end else begin
      $display("two_hop_nonadjacent_neighbors_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
